// ----- hw/rtl/cht_pkg.sv -----
// cht_pkg: shared types and codes for the chained hash table.
// No dependencies.
package cht_pkg;
	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_SEARCH = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2,
		ST_RSVD    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_HEAD,
		BK_READ,
		BK_CHECK,
		BK_DONE
	} bk_state_t;
endpackage

// ----- hw/rtl/cht_front.sv -----
// cht_front: accepts commands, computes the bucket, queues one command.
// Depends on cht_pkg.
module cht_front #(
	parameter int BUCKETS = 17,
	parameter int BW      = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         action,
	input  logic [30:0]        key,
	input  logic [63:0]        payload,
	output logic               busy,
	output logic               q_valid,
	input  logic               q_pop,
	output cht_pkg::action_t   q_action,
	output logic [30:0]        q_key,
	output logic [63:0]        q_payload,
	output logic [BW-1:0]      q_bucket
);
	// bucket = key - floor(key * MULT / 2^SH) * BUCKETS, exact over all 31-bit keys
	localparam int          SH   = 31 + BW;
	localparam logic [31:0] MULT =
		32'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

	logic        have_q;
	logic        cls_valid_s1;
	logic        mul_q;
	logic [1:0]  cls_action_s1;
	logic [30:0] cls_key_s1;
	logic [63:0] cls_payload_s1;
	logic [62:0] prod_s2;
	logic [30:0] quot;
	logic [30:0] rem;

	assign quot = 31'(prod_s2 >> SH);
	assign rem  = cls_key_s1 - 31'(quot * 31'(BUCKETS));
	assign busy = cls_valid_s1 || have_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_valid_s1 <= 1'b0;
			mul_q        <= 1'b0;
			have_q       <= 1'b0;
		end else begin
			if (start && !busy) begin
				cls_valid_s1 <= 1'b1;
				mul_q        <= 1'b1;
			end else if (mul_q) begin
				mul_q <= 1'b0;
			end else if (cls_valid_s1) begin
				cls_valid_s1 <= 1'b0;
				have_q       <= 1'b1;
			end else if (q_pop) begin
				have_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cls_action_s1  <= action;
			cls_key_s1     <= key;
			cls_payload_s1 <= payload;
		end
		if (mul_q)
			prod_s2 <= 63'(cls_key_s1) * 63'(MULT);
		if (cls_valid_s1 && !mul_q) begin
			q_action  <= cht_pkg::action_t'(cls_action_s1);
			q_key     <= cls_key_s1;
			q_payload <= cls_payload_s1;
			q_bucket  <= BW'(rem);
		end
	end

	assign q_valid = have_q;
endmodule

// ----- hw/rtl/cht_back.sv -----
// cht_back: walks bucket chains over the node pool and updates links.
// Depends on cht_pkg.
module cht_back #(
	parameter int BUCKETS    = 17,
	parameter int POOL_NODES = 64,
	parameter int BW         = 5,
	parameter int NW         = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_pop,
	input  cht_pkg::action_t q_action,
	input  logic [30:0]      q_key,
	input  logic [63:0]      q_payload,
	input  logic [BW-1:0]    q_bucket,
	output logic             done,
	output logic [1:0]       status,
	output logic [63:0]      found_payload
);
	localparam logic [NW-1:0] NIL = NW'(POOL_NODES);
	localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;

	logic [NW-1:0]   head_q [BUCKETS];
	logic [POOL_NODES-1:0] used_q;
	logic [30:0]     mkey [POOL_NODES];
	logic [63:0]     mpay [POOL_NODES];
	logic [NW-1:0]   mnext [POOL_NODES];

	cht_pkg::bk_state_t state_q, state_d;
	cht_pkg::action_t   act_q;
	logic [30:0]   key_q;
	logic [63:0]   pay_q;
	logic [BW-1:0] bkt_q;
	logic [NW-1:0] cur_q, prev_q;
	logic [NW:0]   steps_q;
	logic [30:0]   rkey_q;
	logic [63:0]   rpay_q;
	logic [NW-1:0] rnext_q;
	logic          free_any;
	logic [AW-1:0] free_idx;
	logic          cur_ok, hit, walk_end;
	cht_pkg::status_t st_d;

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = POOL_NODES - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_any = 1'b1;
				free_idx = AW'(i);
			end
		end
	end

	assign cur_ok   = (cur_q < NIL) && (steps_q < (NW+1)'(POOL_NODES));
	assign hit      = (rkey_q == key_q);
	assign walk_end = !cur_ok;

	always_comb begin
		state_d = state_q;
		case (state_q)
			cht_pkg::BK_IDLE:  if (q_valid) state_d = cht_pkg::BK_HEAD;
			cht_pkg::BK_HEAD: begin
				if (act_q == cht_pkg::ACT_INSERT || act_q == cht_pkg::ACT_NONE)
					state_d = cht_pkg::BK_DONE;
				else
					state_d = cht_pkg::BK_READ;
			end
			cht_pkg::BK_READ:  state_d = walk_end ? cht_pkg::BK_DONE : cht_pkg::BK_CHECK;
			cht_pkg::BK_CHECK: state_d = hit ? cht_pkg::BK_DONE : cht_pkg::BK_READ;
			cht_pkg::BK_DONE:  state_d = cht_pkg::BK_IDLE;
			default:           state_d = cht_pkg::BK_IDLE;
		endcase
	end

	assign q_pop = (state_q == cht_pkg::BK_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cht_pkg::BK_IDLE;
			used_q  <= '0;
			done    <= 1'b0;
			for (int b = 0; b < BUCKETS; b++)
				head_q[b] <= NIL;
		end else begin
			state_q <= state_d;
			done    <= 1'b0;
			case (state_q)
				cht_pkg::BK_HEAD: begin
					if (act_q == cht_pkg::ACT_INSERT && free_any) begin
						used_q[free_idx] <= 1'b1;
						head_q[bkt_q]    <= NW'(free_idx);
					end
				end
				cht_pkg::BK_CHECK: begin
					if (hit && act_q == cht_pkg::ACT_DELETE) begin
						used_q[cur_q[AW-1:0]] <= 1'b0;
						if (prev_q == NIL)
							head_q[bkt_q] <= rnext_q;
					end
				end
				cht_pkg::BK_DONE: done <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cht_pkg::BK_HEAD && act_q == cht_pkg::ACT_INSERT && free_any) begin
			mkey[free_idx]  <= key_q;
			mpay[free_idx]  <= pay_q;
			mnext[free_idx] <= head_q[bkt_q];
		end
		if (state_q == cht_pkg::BK_CHECK && hit && act_q == cht_pkg::ACT_DELETE &&
			prev_q != NIL)
			mnext[prev_q[AW-1:0]] <= rnext_q;
	end

	always_ff @(posedge clk) begin
		rkey_q  <= mkey[cur_q[AW-1:0]];
		rpay_q  <= mpay[cur_q[AW-1:0]];
		rnext_q <= mnext[cur_q[AW-1:0]];
	end

	always_comb begin
		st_d = cht_pkg::ST_MISSING;
		if (act_q == cht_pkg::ACT_INSERT)
			st_d = free_any ? cht_pkg::ST_OK : cht_pkg::ST_FULL;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cht_pkg::BK_IDLE: begin
				act_q <= q_action;
				key_q <= q_key;
				pay_q <= q_payload;
				bkt_q <= q_bucket;
			end
			cht_pkg::BK_HEAD: begin
				cur_q         <= head_q[bkt_q];
				prev_q        <= NIL;
				steps_q       <= '0;
				status        <= st_d;
				found_payload <= '0;
			end
			cht_pkg::BK_CHECK: begin
				if (hit) begin
					status <= cht_pkg::ST_OK;
					if (act_q == cht_pkg::ACT_SEARCH)
						found_payload <= rpay_q;
				end else begin
					prev_q  <= cur_q;
					cur_q   <= rnext_q;
					steps_q <= steps_q + 1'b1;
				end
			end
			default: ;
		endcase
	end
endmodule

// ----- hw/rtl/chained_hash_table.sv -----
// chained_hash_table: hash table with separate chaining over a node pool.
// Insert and the unused code pass the front, then the back's head and done states;
// search and delete read and check each node passed over, and a match goes to done.
// The front accepts the next command once the back pops the last, while the back walks.
// Reset clears all bucket heads and frees every node at once; done is one cycle, no stall.
module chained_hash_table #(
	parameter int BUCKETS    = 17,
	parameter int POOL_NODES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  action,
	input  logic [30:0] key,
	input  logic [63:0] payload,
	output logic        busy,
	output logic        done,
	output logic [1:0]  status,
	output logic [63:0] found_payload
);
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int NW = $clog2(POOL_NODES + 1);

	logic             q_valid, q_pop;
	cht_pkg::action_t q_action;
	logic [30:0]      q_key;
	logic [63:0]      q_payload;
	logic [BW-1:0]    q_bucket;

	cht_front #(.BUCKETS(BUCKETS), .BW(BW)) u_front (
		.clk, .arst_n, .start, .action, .key, .payload, .busy,
		.q_valid, .q_pop, .q_action, .q_key, .q_payload, .q_bucket
	);

	cht_back #(.BUCKETS(BUCKETS), .POOL_NODES(POOL_NODES), .BW(BW), .NW(NW)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_action, .q_key, .q_payload, .q_bucket,
		.done, .status, .found_payload
	);
endmodule
